// ===== sv/lle_pkg.sv =====
// ============================================================================
// lle_pkg
// Shared types for the linked list engine: opcodes, result codes, controller
// states and the command/status bundles between controller and datapath.
// ============================================================================
package lle_pkg;

    // Operation carried in the input tuser field
    typedef enum logic [2:0] {
        OP_INS_HEAD   = 3'd0,
        OP_INS_TAIL   = 3'd1,
        OP_INS_BEFORE = 3'd2,
        OP_INS_AFTER  = 3'd3,
        OP_DEL_HEAD   = 3'd4,
        OP_DEL_TAIL   = 3'd5,
        OP_DEL_KEY    = 3'd6,
        OP_SEARCH     = 3'd7
    } op_t;

    // Result status
    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } res_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_ALLOC,
        S_ALLOC_WT,
        S_NODE_WR,
        S_SPLICE,
        S_FREE,
        S_OUT
    } state_t;

    // Read address source
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_LINK,
        RD_FREE
    } rd_sel_t;

    // Link written into a freshly allocated node
    typedef enum logic [1:0] {
        NL_HEAD,
        NL_NIL,
        NL_HIT,
        NL_HIT_LINK
    } nl_sel_t;

    // Value written by the splice step
    typedef enum logic [1:0] {
        SV_NEW,
        SV_NIL,
        SV_HIT_LINK
    } sv_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    walk_init;
        logic    walk_step;
        logic    walk_hit;
        logic    alloc_free;
        logic    alloc_new;
        logic    node_wr;
        nl_sel_t nl_sel;
        logic    splice_en;
        logic    splice_hit;   // target is the hit node, else the predecessor
        sv_sel_t sv_sel;
        logic    cnt_inc;
        logic    free_en;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic head_nil;
        logic full;
        logic free_nil;
        logic match;
        logic link_nil;
    } flags_t;

endpackage

// ===== sv/lle_ctrl.sv =====
// ============================================================================
// lle_ctrl
// Controller: sequences one list operation at a time through walk,
// allocate, node write, splice and free steps, and holds the result status.
// ============================================================================
module lle_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  lle_pkg::flags_t flags,
    output lle_pkg::cmd_t   cmd,
    output lle_pkg::res_t   res_status,
    output logic            res_found
);
    import lle_pkg::*;

    state_t state_reg, state_next;
    res_t   status_reg, status_next;
    logic   found_reg, found_next;
    logic   walk_done;
    logic   is_insert;

    // Walk stop condition per operation
    always_comb
    begin
        case (flags.op)
            OP_INS_TAIL, OP_DEL_TAIL: walk_done = flags.link_nil;
            OP_DEL_HEAD:              walk_done = 1'b1;
            default:                  walk_done = flags.match;
        endcase
    end

    assign is_insert = ~flags.op[2];

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        found_next  = found_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = S_START;
                    status_next = RES_OK;
                    found_next  = 1'b0;
                end
            end
            S_START:
            begin
                case (flags.op)
                    OP_INS_HEAD:
                    begin
                        if (flags.full)
                        begin
                            state_next  = S_OUT;
                            status_next = RES_FULL;
                        end
                        else
                            state_next = S_ALLOC;
                    end
                    OP_INS_TAIL:
                    begin
                        if (flags.full)
                        begin
                            state_next  = S_OUT;
                            status_next = RES_FULL;
                        end
                        else if (flags.head_nil)
                            state_next = S_ALLOC;
                        else
                            state_next = S_WALK;
                    end
                    default:
                    begin
                        if (flags.head_nil)
                        begin
                            state_next  = S_OUT;
                            status_next = RES_MISS;
                        end
                        else
                            state_next = S_WALK;
                    end
                endcase
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    case (flags.op)
                        OP_SEARCH:
                        begin
                            state_next = S_OUT;
                            found_next = 1'b1;
                        end
                        OP_INS_BEFORE, OP_INS_AFTER:
                        begin
                            if (flags.full)
                            begin
                                state_next  = S_OUT;
                                status_next = RES_FULL;
                            end
                            else
                                state_next = S_ALLOC;
                        end
                        OP_INS_TAIL: state_next = S_ALLOC;
                        default:     state_next = S_SPLICE;
                    endcase
                end
                else if (flags.link_nil)
                begin
                    state_next  = S_OUT;
                    status_next = RES_MISS;
                end
            end
            S_ALLOC:    state_next = flags.free_nil ? S_NODE_WR : S_ALLOC_WT;
            S_ALLOC_WT: state_next = S_NODE_WR;
            S_NODE_WR:  state_next = S_SPLICE;
            S_SPLICE:   state_next = is_insert ? S_OUT : S_FREE;
            S_FREE:     state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.load_op = in_valid;
            S_START:
            begin
                cmd.walk_init = 1'b1;
                cmd.rd_en     = ~flags.head_nil;
                cmd.rd_sel    = RD_HEAD;
            end
            S_WALK:
            begin
                if (walk_done)
                    cmd.walk_hit = 1'b1;
                else
                begin
                    cmd.walk_step = ~flags.link_nil;
                    cmd.rd_en     = ~flags.link_nil;
                    cmd.rd_sel    = RD_LINK;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_new = flags.free_nil;
                cmd.rd_en     = ~flags.free_nil;
                cmd.rd_sel    = RD_FREE;
            end
            S_ALLOC_WT: cmd.alloc_free = 1'b1;
            S_NODE_WR:
            begin
                cmd.node_wr = 1'b1;
                case (flags.op)
                    OP_INS_HEAD:   cmd.nl_sel = NL_HEAD;
                    OP_INS_BEFORE: cmd.nl_sel = NL_HIT;
                    OP_INS_AFTER:  cmd.nl_sel = NL_HIT_LINK;
                    default:       cmd.nl_sel = NL_NIL;
                endcase
            end
            S_SPLICE:
            begin
                cmd.splice_en  = 1'b1;
                cmd.cnt_inc    = is_insert;
                cmd.splice_hit = (flags.op == OP_INS_TAIL) || (flags.op == OP_INS_AFTER);
                case (flags.op)
                    OP_DEL_TAIL:             cmd.sv_sel = SV_NIL;
                    OP_DEL_HEAD, OP_DEL_KEY: cmd.sv_sel = SV_HIT_LINK;
                    default:                 cmd.sv_sel = SV_NEW;
                endcase
            end
            S_FREE:  cmd.free_en = 1'b1;
            S_OUT:   cmd = '0;
            default: cmd = '0;
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign res_status = status_reg;
    assign res_found  = found_reg;

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= RES_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

endmodule

// ===== sv/lle_datapath.sv =====
// ============================================================================
// lle_datapath
// Node store (value and link memories), list and free-list pointers, node
// counter and walk registers of the linked list engine.
// ============================================================================
module lle_datapath
#(
    parameter int CAPACITY = 64,
    parameter int IW       = 7,
    parameter int AW       = 6,
    parameter int OUT_W    = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lle_pkg::cmd_t     cmd,
    input  lle_pkg::op_t      in_op,
    input  logic [31:0]       in_value,
    input  logic [31:0]       in_key,
    input  logic              res_found,
    output lle_pkg::flags_t   flags,
    output logic [OUT_W-1:0]  position,
    output logic [OUT_W-1:0]  length
);
    import lle_pkg::*;

    localparam logic [IW-1:0] NIL = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE = IW'(1);

    // Node store
    logic [31:0]   val_mem  [CAPACITY];
    logic [IW-1:0] link_mem [CAPACITY];

    logic [31:0]   rd_val_reg;
    logic [IW-1:0] rd_link_reg;
    logic [IW-1:0] rd_addr;

    op_t           op_reg;
    logic [31:0]   value_reg;
    logic [31:0]   key_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] free_head_reg;
    logic [IW-1:0] never_used_reg;
    logic [IW-1:0] count_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] prev_reg;
    logic [IW-1:0] hit_reg;
    logic [IW-1:0] hit_link_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] new_reg;

    logic [IW-1:0] new_link;
    logic [IW-1:0] sp_tgt;
    logic [IW-1:0] sp_val;
    logic          lw_en;
    logic [IW-1:0] lw_addr;
    logic [IW-1:0] lw_data;

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_LINK: rd_addr = rd_link_reg;
            RD_FREE: rd_addr = free_head_reg;
            default: rd_addr = head_reg;
        endcase
    end

    // Link of a fresh node
    always_comb
    begin
        case (cmd.nl_sel)
            NL_HEAD:     new_link = head_reg;
            NL_HIT:      new_link = hit_reg;
            NL_HIT_LINK: new_link = hit_link_reg;
            default:     new_link = NIL;
        endcase
    end

    // Splice target and value
    assign sp_tgt = cmd.splice_hit ? hit_reg : prev_reg;
    always_comb
    begin
        case (cmd.sv_sel)
            SV_NEW:      sp_val = new_reg;
            SV_HIT_LINK: sp_val = hit_link_reg;
            default:     sp_val = NIL;
        endcase
    end

    // Link memory write port
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = new_reg;
        lw_data = new_link;
        if (cmd.node_wr)
            lw_en = 1'b1;
        else if (cmd.splice_en && (sp_tgt != NIL))
        begin
            lw_en   = 1'b1;
            lw_addr = sp_tgt;
            lw_data = sp_val;
        end
        else if (cmd.free_en)
        begin
            lw_en   = 1'b1;
            lw_addr = hit_reg;
            lw_data = free_head_reg;
        end
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.node_wr)
            val_mem[new_reg[AW-1:0]] <= value_reg;
        if (lw_en)
            link_mem[lw_addr[AW-1:0]] <= lw_data;
        if (cmd.rd_en)
        begin
            rd_val_reg  <= val_mem[rd_addr[AW-1:0]];
            rd_link_reg <= link_mem[rd_addr[AW-1:0]];
        end
    end

    // Input capture and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
            key_reg   <= in_key;
        end
        if (cmd.walk_init)
        begin
            cur_reg  <= head_reg;
            prev_reg <= NIL;
            hit_reg  <= NIL;
            pos_reg  <= ONE;
        end
        else if (cmd.walk_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link_reg;
            pos_reg  <= pos_reg + ONE;
        end
        if (cmd.walk_hit)
        begin
            hit_reg      <= cur_reg;
            hit_link_reg <= rd_link_reg;
        end
        if (cmd.alloc_free)
            new_reg <= free_head_reg;
        else if (cmd.alloc_new)
            new_reg <= never_used_reg;
    end

    // List pointers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= NIL;
            free_head_reg  <= NIL;
            never_used_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cmd.alloc_free)
                free_head_reg <= rd_link_reg;
            else if (cmd.free_en)
                free_head_reg <= hit_reg;
            if (cmd.alloc_new)
                never_used_reg <= never_used_reg + ONE;
            if (cmd.splice_en && (sp_tgt == NIL))
                head_reg <= sp_val;
            if (cmd.splice_en && cmd.cnt_inc)
                count_reg <= count_reg + ONE;
            else if (cmd.free_en)
                count_reg <= count_reg - ONE;
        end
    end

    // Status to controller
    assign flags.op       = op_reg;
    assign flags.head_nil = (head_reg == NIL);
    assign flags.full     = (count_reg == NIL);
    assign flags.free_nil = (free_head_reg == NIL);
    assign flags.match    = (rd_val_reg == key_reg);
    assign flags.link_nil = (rd_link_reg == NIL);

    // Result fields
    assign position = res_found ? OUT_W'(pos_reg) : '0;
    assign length   = OUT_W'(count_reg);

endmodule

// ===== sv/linked_list_engine_top.sv =====
// Sequence: a start step and the walk where the operation needs one, then the
//   allocate, node write and splice steps for an insert (splice and free for a
//   delete) before the result is offered.
// Throughput: one operation at a time; a new input is taken only when idle, and
//   the walk reads one node per cycle from the single read port.
// Reset: empty list, empty free list, node count zero; node store unset.
// ============================================================================
// linked_list_engine_top
// Bounded singly linked list of signed 32-bit values with insert, delete
// and search operations over stream interfaces.
// ============================================================================
module linked_list_engine_top
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[31:0], key[63:32]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[6:0], length[13:7], zero[15:14]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import lle_pkg::*;

    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int OUT_W = 7;

    cmd_t             cmd;
    flags_t           flags;
    res_t             res_status;
    logic             res_found;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] length;

    // Controller
    lle_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .flags      (flags),
        .cmd        (cmd),
        .res_status (res_status),
        .res_found  (res_found)
    );

    // Datapath
    lle_datapath
    #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .AW       (AW),
        .OUT_W    (OUT_W)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (op_t'(s_tuser)),
        .in_value  (s_tdata[31:0]),
        .in_key    (s_tdata[63:32]),
        .res_found (res_found),
        .flags     (flags),
        .position  (position),
        .length    (length)
    );

    // Result transfer
    assign m_tdata = {2'b00, length, position};
    assign m_tuser = res_status;

endmodule
